// File: src/apmd_pkg.sv
// Shared types, register map and constants for the angular PID motor drive.
package apmd_pkg;

    // Field widths
    localparam int ANGLE_W = 9;
    localparam int ERR_W   = 10;
    localparam int DIFF_W  = 10;
    localparam int TOTAL_W = 32;
    localparam int GAIN_W  = 24;
    localparam int BYTE_W  = 8;
    localparam int FRAC_W  = 16;

    // Product and sum widths (gain widened by a sign bit)
    localparam int PROP_W  = GAIN_W + 1 + ERR_W;
    localparam int DERIV_W = GAIN_W + 1 + DIFF_W;
    localparam int INTEG_W = GAIN_W + 1 + TOTAL_W;
    localparam int SUM_W   = INTEG_W + 1;
    localparam int SPEED_W = SUM_W - FRAC_W;

    // Angle folding
    localparam int FULL_TURN = 360;
    localparam int HALF_TURN = 180;

    // APB port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes
    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_DERIV_GAIN    = 3'd1,
        REG_INTEG_GAIN    = 3'd2,
        REG_SPEED_CEILING = 3'd3,
        REG_SPEED_FLOOR   = 3'd4,
        REG_DEAD_BAND_LOW = 3'd5
    } t_reg_idx;

    // Register reset values
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 24'd15073;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN    = 24'd6554;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN    = 24'd7;
    localparam logic [BYTE_W-1:0] RST_SPEED_CEILING = 8'd70;
    localparam logic [BYTE_W-1:0] RST_SPEED_FLOOR   = 8'd20;
    localparam logic [BYTE_W-1:0] RST_DEAD_BAND_LOW = 8'd5;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [BYTE_W-1:0] speed_ceiling;
        logic [BYTE_W-1:0] speed_floor;
        logic [BYTE_W-1:0] dead_band_low;
    } t_cfg;

endpackage

// File: src/apmd_regs.sv
// APB configuration register file for the angular PID motor drive.
module apmd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apmd_pkg::ADDR_W-1:0]   paddr,
    input  logic [apmd_pkg::DATA_W-1:0]   pwdata,
    output logic [apmd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output apmd_pkg::t_cfg                o_cfg
);

    apmd_pkg::t_cfg     r_cfg;
    apmd_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = apmd_pkg::t_reg_idx'(paddr[apmd_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Write the addressed register; drop writes beyond the map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= apmd_pkg::RST_PROP_GAIN;
            r_cfg.deriv_gain    <= apmd_pkg::RST_DERIV_GAIN;
            r_cfg.integ_gain    <= apmd_pkg::RST_INTEG_GAIN;
            r_cfg.speed_ceiling <= apmd_pkg::RST_SPEED_CEILING;
            r_cfg.speed_floor   <= apmd_pkg::RST_SPEED_FLOOR;
            r_cfg.dead_band_low <= apmd_pkg::RST_DEAD_BAND_LOW;
        end else if (wr_en) begin
            case (reg_idx)
                apmd_pkg::REG_PROP_GAIN: begin
                    r_cfg.prop_gain <= pwdata[apmd_pkg::GAIN_W-1:0];
                end
                apmd_pkg::REG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= pwdata[apmd_pkg::GAIN_W-1:0];
                end
                apmd_pkg::REG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= pwdata[apmd_pkg::GAIN_W-1:0];
                end
                apmd_pkg::REG_SPEED_CEILING: begin
                    r_cfg.speed_ceiling <= pwdata[apmd_pkg::BYTE_W-1:0];
                end
                apmd_pkg::REG_SPEED_FLOOR: begin
                    r_cfg.speed_floor <= pwdata[apmd_pkg::BYTE_W-1:0];
                end
                apmd_pkg::REG_DEAD_BAND_LOW: begin
                    r_cfg.dead_band_low <= pwdata[apmd_pkg::BYTE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Return the addressed register, zero for holes
    always_comb begin
        case (reg_idx)
            apmd_pkg::REG_PROP_GAIN:     prdata = apmd_pkg::DATA_W'(r_cfg.prop_gain);
            apmd_pkg::REG_DERIV_GAIN:    prdata = apmd_pkg::DATA_W'(r_cfg.deriv_gain);
            apmd_pkg::REG_INTEG_GAIN:    prdata = apmd_pkg::DATA_W'(r_cfg.integ_gain);
            apmd_pkg::REG_SPEED_CEILING: prdata = apmd_pkg::DATA_W'(r_cfg.speed_ceiling);
            apmd_pkg::REG_SPEED_FLOOR:   prdata = apmd_pkg::DATA_W'(r_cfg.speed_floor);
            apmd_pkg::REG_DEAD_BAND_LOW: prdata = apmd_pkg::DATA_W'(r_cfg.dead_band_low);
            default:                     prdata = '0;
        endcase
    end

endmodule

// File: src/angular_pid_motor_drive.sv
// A result is valid once its request has passed the five register stages (input,
// fold, multiply, sum, output). Throughput: one request per cycle while no stage
// stalls; each stage stalls only when the stage after it is full and not draining.
// The error history is updated as a request leaves the input stage, so requests
// may follow back to back. Reset (synchronous, active low) empties the pipeline,
// clears the error history and loads the register defaults.
module angular_pid_motor_drive (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [8:0] target_angle, [17:9] measured_angle, [23:18] zero
    input  logic [23:0]                   s_axis_tdata,
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] direction, [8:1] drive_speed, [15:9] zero
    output logic [15:0]                   m_axis_tdata,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apmd_pkg::ADDR_W-1:0]   paddr,
    input  logic [apmd_pkg::DATA_W-1:0]   pwdata,
    output logic [apmd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = apmd_pkg::ANGLE_W;
    localparam int EW = apmd_pkg::ERR_W;

    apmd_pkg::t_cfg cfg;

    apmd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Stage valids and payloads
    logic                                 r_v1, r_v2, r_v3, r_v4, r_vo;
    logic [AW-1:0]                        r_tgt, r_meas;
    logic                                 r_dir2, r_dir3, r_dir4, r_dir_o;
    logic signed [EW-1:0]                 r_err2;
    logic signed [apmd_pkg::DIFF_W-1:0]   r_diff2;
    logic signed [apmd_pkg::TOTAL_W-1:0]  r_tot2;
    logic signed [apmd_pkg::PROP_W-1:0]   r_p3;
    logic signed [apmd_pkg::DERIV_W-1:0]  r_d3;
    logic signed [apmd_pkg::INTEG_W-1:0]  r_i3;
    logic signed [apmd_pkg::SUM_W-1:0]    r_sum4;
    logic [apmd_pkg::BYTE_W-1:0]          r_spd_o;

    // Error history
    logic signed [EW-1:0]                 r_prev_err;
    logic signed [apmd_pkg::TOTAL_W-1:0]  r_err_total;

    // Stage advance
    logic rdy1, rdy2, rdy3, rdy4, rdyo;
    assign rdyo = !r_vo || m_axis_tready;
    assign rdy4 = !r_v4 || rdyo;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {7'd0, r_spd_o, r_dir_o};

    // Fold the raw error into half a turn and pick a direction
    logic signed [EW:0]   raw_err;
    logic signed [EW:0]   fold_wide;
    logic signed [EW-1:0] n_err;
    logic                 n_dir;
    logic signed [apmd_pkg::DIFF_W-1:0]    n_diff;
    logic signed [apmd_pkg::TOTAL_W:0]     tot_sum;
    logic signed [apmd_pkg::TOTAL_W-1:0]   n_total;
    localparam logic signed [EW:0] FULL = (EW+1)'(apmd_pkg::FULL_TURN);
    localparam logic signed [EW:0] HALF = (EW+1)'(apmd_pkg::HALF_TURN);

    always_comb begin
        raw_err = $signed({2'b00, r_tgt}) - $signed({2'b00, r_meas});
        if (raw_err < 0 && raw_err >= -HALF) begin
            n_dir     = 1'b1;
            fold_wide = raw_err;
        end else if (raw_err < -HALF) begin
            n_dir     = 1'b0;
            fold_wide = -FULL - raw_err;
        end else if (raw_err < HALF) begin
            n_dir     = 1'b0;
            fold_wide = raw_err;
        end else begin
            n_dir     = 1'b1;
            fold_wide = FULL - raw_err;
        end
        n_err  = fold_wide[EW-1:0];
        n_diff = apmd_pkg::DIFF_W'(n_err - r_prev_err);
        // Saturating accumulate
        tot_sum = (apmd_pkg::TOTAL_W+1)'(r_err_total) + (apmd_pkg::TOTAL_W+1)'(n_err);
        if (tot_sum[apmd_pkg::TOTAL_W] != tot_sum[apmd_pkg::TOTAL_W-1]) begin
            n_total = tot_sum[apmd_pkg::TOTAL_W]
                ? {1'b1, {(apmd_pkg::TOTAL_W-1){1'b0}}}
                : {1'b0, {(apmd_pkg::TOTAL_W-1){1'b1}}};
        end else begin
            n_total = tot_sum[apmd_pkg::TOTAL_W-1:0];
        end
    end

    // Products, sum, magnitude and clamp
    logic signed [apmd_pkg::PROP_W-1:0]  n_p;
    logic signed [apmd_pkg::DERIV_W-1:0] n_d;
    logic signed [apmd_pkg::INTEG_W-1:0] n_i;
    logic signed [apmd_pkg::SUM_W-1:0]   n_sum;
    logic [apmd_pkg::SUM_W-1:0]          mag;
    logic [apmd_pkg::SPEED_W-1:0]        speed;
    logic [apmd_pkg::BYTE_W-1:0]         n_spd;

    always_comb begin
        n_p   = $signed({1'b0, cfg.prop_gain}) * r_err2;
        n_d   = $signed({1'b0, cfg.deriv_gain}) * r_diff2;
        n_i   = $signed({1'b0, cfg.integ_gain}) * r_tot2;
        n_sum = apmd_pkg::SUM_W'(r_p3) + apmd_pkg::SUM_W'(r_d3) + apmd_pkg::SUM_W'(r_i3);
        mag   = r_sum4[apmd_pkg::SUM_W-1] ? (~r_sum4 + 1'b1) : r_sum4;
        speed = mag[apmd_pkg::SUM_W-1:apmd_pkg::FRAC_W];
        if (speed > apmd_pkg::SPEED_W'(cfg.speed_ceiling)) begin
            n_spd = cfg.speed_ceiling;
        end else if (speed[apmd_pkg::BYTE_W-1:0] < cfg.speed_floor
                     && speed[apmd_pkg::BYTE_W-1:0] >= cfg.dead_band_low) begin
            n_spd = cfg.speed_floor;
        end else begin
            n_spd = speed[apmd_pkg::BYTE_W-1:0];
        end
    end

    // Advance valids and the error history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_vo        <= 1'b0;
            r_prev_err  <= '0;
            r_err_total <= '0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdyo) r_vo <= r_v4;
            if (r_v1 && rdy2) begin
                r_prev_err  <= n_err;
                r_err_total <= n_total;
            end
        end
    end

    // Move payloads with their stage
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_tgt  <= s_axis_tdata[AW-1:0];
            r_meas <= s_axis_tdata[2*AW-1:AW];
        end
        if (rdy2) begin
            r_dir2  <= n_dir;
            r_err2  <= n_err;
            r_diff2 <= n_diff;
            r_tot2  <= r_err_total;
        end
        if (rdy3) begin
            r_dir3 <= r_dir2;
            r_p3   <= n_p;
            r_d3   <= n_d;
            r_i3   <= n_i;
        end
        if (rdy4) begin
            r_dir4 <= r_dir3;
            r_sum4 <= n_sum;
        end
        if (rdyo) begin
            r_dir_o <= r_dir4;
            r_spd_o <= n_spd;
        end
    end

endmodule
